@@ src/gcr_pkg.sv @@
// Package with payload types and operation codes for the graph cycle and reach engine.
package gcr_pkg;
  localparam logic [2:0] OP_ADD   = 3'd0;
  localparam logic [2:0] OP_NODE  = 3'd1;
  localparam logic [2:0] OP_GRAPH = 3'd2;
  localparam logic [2:0] OP_REACH = 3'd3;
  localparam logic [2:0] OP_DEST  = 3'd4;

  localparam logic [6:0] NUM_VERTICES_RESET = 7'd64;

  typedef struct packed {
    logic [2:0] operation;
    logic [5:0] src_node;
    logic [5:0] dst_node;
  } gcr_in_t;

  typedef struct packed {
    logic        answer;
    logic [63:0] dest_mask;
    logic        status;
  } gcr_out_t;
endpackage

@@ src/graph_cycle_and_reach_engine.sv @@
// Top level of the graph cycle and reach engine: adjacency memory and search sequencer.
// Add edge and destinations pass through S_ROW and S_DONE before their result is offered. A
// search steps through stack read (S_RD), row read (S_POP) and scan (S_SCAN) for every edge
// it follows and every pop, plus a stack write (S_PUSH) for every push; a graph query also
// steps through S_ROOT for each root. One item is worked at a time: the next word is taken
// only after the result has been taken. Reset is synchronous, active low; afterwards the
// adjacency matrix is cleared row by row (S_CLEAR) before the first word is accepted.
module graph_cycle_and_reach_engine import gcr_pkg::*; #(
  parameter int MAX_VERTICES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  gcr_in_t     in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output gcr_out_t    out_data,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CW = $clog2(MAX_VERTICES + 1);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_ROW   = 4'd2;  // wait for row read of add / dest
  localparam logic [3:0] S_ROOT  = 4'd3;  // start search from root
  localparam logic [3:0] S_RD    = 4'd4;  // read top of stack entry; its row is read in S_POP
  localparam logic [3:0] S_SCAN  = 4'd5;  // examine row
  localparam logic [3:0] S_POP   = 4'd6;
  localparam logic [3:0] S_DONE  = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;
  localparam logic [3:0] S_PUSH  = 4'd9;  // write the newly pushed stack entry

  logic [3:0]        state_r, state_nxt;
  logic [6:0]        nv_r;
  logic [CW-1:0]     n_w;
  logic [63:0]       rmask_w;

  // Memories.
  logic [63:0]       adj_mem [MAX_VERTICES];
  logic [12:0]       stk_mem [MAX_VERTICES];
  logic [63:0]       adj_q_r;
  logic [12:0]       stk_q_r;
  logic              adj_we, stk_we;
  logic [AW-1:0]     adj_waddr, adj_raddr, stk_addr;
  logic [63:0]       adj_wdata;
  logic [12:0]       stk_wdata;

  gcr_in_t           item_r;
  gcr_out_t          res_r;
  logic              out_valid_r;
  logic [63:0]       vis_r, vis_nxt, onp_r, onp_nxt;
  logic [CW-1:0]     depth_r, depth_nxt;
  logic [CW-1:0]     root_r, root_nxt;
  logic [AW-1:0]     clr_r;
  logic              ans_r, ans_nxt;
  logic [5:0]        cur_v_r;
  logic [6:0]        cur_j_r;
  logic [5:0]        push_v_r;

  assign n_w = (nv_r > 7'(MAX_VERTICES)) ? CW'(MAX_VERTICES) : CW'(nv_r);
  assign rmask_w = (7'(n_w) >= 7'd64) ? '1 : ((64'd1 << n_w) - 64'd1);

  // Config port.
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == 2'd0) ? {25'd0, nv_r} : 32'd0;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nv_r <= NUM_VERTICES_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == 2'd0) begin
      nv_r <= cfg_pwdata[6:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adj_we) begin
      adj_mem[adj_waddr] <= adj_wdata;
    end
    adj_q_r <= adj_mem[adj_raddr];
  end
  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_addr] <= stk_wdata;
    end
    stk_q_r <= stk_mem[stk_addr];
  end

  // Scan of current row from the stored next-neighbor index.
  logic [63:0] cand_w, lowm_w;
  logic        found_w;
  logic [5:0]  jf_w;
  logic        isq_reach;
  assign isq_reach = (item_r.operation == OP_REACH);
  always_comb begin
    lowm_w = (cur_j_r >= 7'd64) ? 64'd0 : ~((64'd1 << cur_j_r[5:0]) - 64'd1);
    cand_w = adj_q_r & rmask_w & lowm_w & (isq_reach ? ~vis_r : '1);
    found_w = |cand_w;
    jf_w = '0;
    for (int k = 63; k >= 0; k--) begin
      if (cand_w[k]) begin
        jf_w = 6'(k);
      end
    end
  end

  logic in_acc;
  assign in_ready = (state_r == S_IDLE) && !out_valid_r;
  assign in_acc   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = res_r;

  logic src_bad, dst_bad;
  assign src_bad = CW'(item_r.src_node) >= n_w;
  assign dst_bad = CW'(item_r.dst_node) >= n_w;

  always_comb begin
    state_nxt = state_r;
    vis_nxt   = vis_r;
    onp_nxt   = onp_r;
    depth_nxt = depth_r;
    root_nxt  = root_r;
    ans_nxt   = ans_r;
    adj_we    = 1'b0;
    adj_waddr = item_r.src_node[AW-1:0];
    adj_wdata = adj_q_r | (64'd1 << item_r.dst_node);
    adj_raddr = item_r.src_node[AW-1:0];
    stk_we    = 1'b0;
    stk_addr  = '0;
    stk_wdata = '0;
    if (depth_r != '0) begin
      stk_addr = AW'(depth_r - CW'(1));
    end
    unique case (state_r)
      S_CLEAR: begin
        adj_we    = 1'b1;
        adj_waddr = clr_r;
        adj_wdata = '0;
        if (clr_r == AW'(MAX_VERTICES - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        adj_raddr = in_data.src_node[AW-1:0];
        if (in_acc) begin
          vis_nxt = '0;
          onp_nxt = '0;
          depth_nxt = '0;
          root_nxt = '0;
          ans_nxt = 1'b0;
          case (in_data.operation) inside
            OP_ADD, OP_DEST: state_nxt = S_ROW;
            OP_NODE, OP_GRAPH, OP_REACH: state_nxt = S_ROOT;
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_ROW: begin
        if (item_r.operation == OP_ADD && !src_bad && !dst_bad) begin
          adj_we = 1'b1;
        end
        state_nxt = S_DONE;
      end
      S_ROOT: begin
        if (item_r.operation == OP_GRAPH) begin
          if (root_r >= n_w) begin
            state_nxt = S_DONE;
          end else if (vis_r[root_r[5:0]]) begin
            root_nxt = root_r + CW'(1);
          end else begin
            vis_nxt[root_r[5:0]] = 1'b1;
            onp_nxt[root_r[5:0]] = 1'b1;
            stk_we = 1'b1;
            stk_addr = '0;
            stk_wdata = {7'd0, 6'(root_r)};
            depth_nxt = CW'(1);
            state_nxt = S_RD;
          end
        end else if (src_bad || (isq_reach && dst_bad)) begin
          state_nxt = S_DONE;
        end else begin
          if (!isq_reach) begin
            vis_nxt[item_r.src_node] = 1'b1;
            onp_nxt[item_r.src_node] = 1'b1;
          end
          stk_we = 1'b1;
          stk_addr = '0;
          stk_wdata = {7'd0, item_r.src_node};
          depth_nxt = CW'(1);
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        // Stack read issued this cycle; row read follows next cycle.
        if (depth_r == '0) begin
          if (item_r.operation == OP_GRAPH) begin
            root_nxt = root_r + CW'(1);
            state_nxt = S_ROOT;
          end else begin
            state_nxt = S_DONE;
          end
        end else begin
          state_nxt = S_POP;
        end
      end
      S_POP: begin
        adj_raddr = stk_q_r[5:0];
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (!found_w) begin
          if (!isq_reach) begin
            onp_nxt[cur_v_r] = 1'b0;
          end
          depth_nxt = depth_r - CW'(1);
          state_nxt = S_RD;
        end else begin
          stk_we = 1'b1;
          stk_wdata = {7'(jf_w) + 7'd1, cur_v_r};
          state_nxt = S_RD;
          if (isq_reach) begin
            vis_nxt[jf_w] = 1'b1;
            if (jf_w == item_r.dst_node) begin
              ans_nxt = 1'b1;
              state_nxt = S_DONE;
            end else if (jf_w != item_r.src_node && depth_r < CW'(MAX_VERTICES)) begin
              depth_nxt = depth_r + CW'(1);
              state_nxt = S_PUSH;
            end
          end else if (!vis_r[jf_w]) begin
            vis_nxt[jf_w] = 1'b1;
            onp_nxt[jf_w] = 1'b1;
            if (depth_r < CW'(MAX_VERTICES)) begin
              depth_nxt = depth_r + CW'(1);
              state_nxt = S_PUSH;
            end
          end else if (onp_r[jf_w]) begin
            ans_nxt = 1'b1;
            state_nxt = S_DONE;
          end
        end
      end
      S_PUSH: begin
        // The scan has already updated the parent entry; now the new top is written.
        stk_we = 1'b1;
        stk_wdata = {7'd0, push_v_r};
        state_nxt = S_RD;
      end
      S_DONE: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      vis_r       <= '0;
      onp_r       <= '0;
      depth_r     <= '0;
      root_r      <= '0;
      ans_r       <= 1'b0;
    end else begin
      state_r <= state_nxt;
      vis_r   <= vis_nxt;
      onp_r   <= onp_nxt;
      depth_r <= depth_nxt;
      root_r  <= root_nxt;
      ans_r   <= ans_nxt;
      if (state_r == S_CLEAR) begin
        clr_r <= clr_r + AW'(1);
      end
      if (state_r == S_DONE) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_r <= in_data;
    end
    if (state_r == S_POP) begin
      cur_v_r <= stk_q_r[5:0];
      cur_j_r <= stk_q_r[12:6];
    end
    if (state_r == S_SCAN) begin
      push_v_r <= jf_w;
    end
    if (state_r == S_DONE) begin
      res_r.status    <= 1'b0;
      res_r.answer    <= 1'b0;
      res_r.dest_mask <= '0;
      case (item_r.operation)
        OP_ADD: res_r.status <= src_bad || dst_bad;
        OP_NODE: begin
          res_r.status <= src_bad;
          res_r.answer <= ans_r && !src_bad;
        end
        OP_GRAPH: res_r.answer <= ans_r;
        OP_REACH: begin
          res_r.status <= src_bad || dst_bad;
          res_r.answer <= ans_r && !src_bad && !dst_bad;
        end
        OP_DEST: begin
          res_r.status <= src_bad;
          res_r.dest_mask <= src_bad ? 64'd0 : (adj_q_r & rmask_w);
        end
        default: ;
      endcase
    end
  end

  property p_one_out;
    @(posedge clk) disable iff (!rst_n) out_valid && !out_ready |=> out_valid;
  endproperty
  a_hold: assert property (p_one_out) else $error("result dropped");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("accept while result pending");
  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= CW'(MAX_VERTICES)) else $error("stack overflow");
endmodule

@@ verif/tb_graph_cycle_and_reach_engine.sv @@
// Testbench for the graph cycle and reach engine: directed table, random phases, predictor.
`timescale 1ns / 100ps

module tb_graph_cycle_and_reach_engine;
  import gcr_pkg::*;

  localparam int NODES = 64;
  localparam int STALL_LIMIT = 40000;
  localparam int RAND_PER_PHASE = 120;

  typedef struct {
    logic [2:0]  op;
    logic [5:0]  src;
    logic [5:0]  dst;
    int          cfg;      // count to program before the row, or -1
    bit          typed;    // expected result given in the row
    gcr_out_t    want;
  } table_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  gcr_in_t     in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  gcr_out_t    out_data;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [1:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // Shadow of the block's graph and configuration.
  logic [63:0] adj_rows [NODES];
  logic [63:0] seen_marks;
  logic [63:0] path_marks;
  int          vert_cfg = 64;

  gcr_out_t    pending_answers [$];
  int          errors = 0;
  int          idle_pct = 0;
  int          stall_pct = 0;
  int          quiet_cycles = 0;

  graph_cycle_and_reach_engine dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int node_limit();
    return (vert_cfg > NODES) ? NODES : vert_cfg;
  endfunction

  // Depth-first search for a back edge; marks persist across roots of one query.
  function automatic bit cycle_reachable(int root, int n);
    int sn [NODES];
    int sj [NODES];
    int depth;
    int top;
    int v;
    int j;
    if (seen_marks[root]) return 1'b0;
    seen_marks[root] = 1'b1;
    path_marks[root] = 1'b1;
    sn[0] = root;
    sj[0] = 0;
    depth = 1;
    while (depth > 0) begin
      top = depth - 1;
      v = sn[top];
      j = sj[top];
      while (j < n && !adj_rows[v][j]) j++;
      if (j >= n) begin
        path_marks[v] = 1'b0;
        depth = top;
        continue;
      end
      sj[top] = j + 1;
      if (!seen_marks[j]) begin
        seen_marks[j] = 1'b1;
        path_marks[j] = 1'b1;
        if (depth < NODES) begin
          sn[depth] = j;
          sj[depth] = 0;
          depth++;
        end
      end else if (path_marks[j]) begin
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Path of one or more edges; the start node is never pushed a second time.
  function automatic bit path_exists(int src, int dst, int n);
    int sn [NODES];
    int sj [NODES];
    int depth;
    int top;
    int v;
    int j;
    seen_marks = '0;
    sn[0] = src;
    sj[0] = 0;
    depth = 1;
    while (depth > 0) begin
      top = depth - 1;
      v = sn[top];
      j = sj[top];
      while (j < n && !(adj_rows[v][j] && !seen_marks[j])) j++;
      if (j >= n) begin
        depth = top;
        continue;
      end
      sj[top] = j + 1;
      seen_marks[j] = 1'b1;
      if (j == dst) return 1'b1;
      if (j != src && depth < NODES) begin
        sn[depth] = j;
        sj[depth] = 0;
        depth++;
      end
    end
    return 1'b0;
  endfunction

  function automatic gcr_out_t graph_answer(gcr_in_t w);
    gcr_out_t r;
    int n;
    n = node_limit();
    r = '0;
    seen_marks = '0;
    path_marks = '0;
    case (w.operation)
      OP_ADD: begin
        if (w.src_node >= n || w.dst_node >= n) r.status = 1'b1;
        else adj_rows[w.src_node][w.dst_node] = 1'b1;
      end
      OP_NODE: begin
        if (w.src_node >= n) r.status = 1'b1;
        else r.answer = cycle_reachable(w.src_node, n);
      end
      OP_GRAPH: begin
        for (int i = 0; i < n && !r.answer; i++) r.answer = cycle_reachable(i, n);
      end
      OP_REACH: begin
        if (w.src_node >= n || w.dst_node >= n) r.status = 1'b1;
        else r.answer = path_exists(w.src_node, w.dst_node, n);
      end
      OP_DEST: begin
        if (w.src_node >= n) r.status = 1'b1;
        else r.dest_mask = adj_rows[w.src_node] &
                           ((n >= 64) ? ~64'd0 : ((64'd1 << n) - 64'd1));
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic wait_drained();
    while (pending_answers.size() != 0) @(posedge clk);
  endtask

  task automatic write_vertex_count(int value);
    in_valid <= 1'b0;
    wait_drained();
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= '0;
    cfg_pwdata <= 32'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    vert_cfg = value & 127;
  endtask

  // Sends one word; valid stays high between back-to-back words.
  task automatic send_word(gcr_in_t w, bit typed, gcr_out_t want);
    gcr_out_t guess;
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (!in_ready);
    guess = graph_answer(w);
    pending_answers.push_back(typed ? want : guess);
  endtask

  function automatic gcr_in_t random_word();
    gcr_in_t w;
    int n;
    int pick;
    n = node_limit();
    pick = $urandom_range(99);
    w.operation = OP_ADD;
    w.src_node = (n > 0) ? 6'($urandom_range(n - 1)) : 6'($urandom);
    w.dst_node = (n > 0) ? 6'($urandom_range(n - 1)) : 6'($urandom);
    if (pick < 38) begin
      // Mostly forward edges so that cycles stay the exception.
      if (w.src_node > w.dst_node && $urandom_range(99) < 75)
        {w.src_node, w.dst_node} = {w.dst_node, w.src_node};
    end else if (pick < 53) w.operation = OP_NODE;
    else if (pick < 61) w.operation = OP_GRAPH;
    else if (pick < 81) w.operation = OP_REACH;
    else if (pick < 91) w.operation = OP_DEST;
    else if (pick < 94) w.operation = 3'($urandom_range(5, 7));
    else begin
      w.operation = 3'($urandom_range(OP_ADD, OP_DEST));
      w.src_node = 6'($urandom);
      w.dst_node = 6'($urandom);
    end
    return w;
  endfunction

  always @(posedge clk) begin
    gcr_out_t exp_word;
    if (rst_n) out_ready <= ($urandom_range(99) >= stall_pct);
    if (out_valid && out_ready) begin
      if (pending_answers.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data);
        errors++;
      end else begin
        exp_word = pending_answers.pop_front();
        if (out_data.answer !== exp_word.answer) begin
          $display("%0t: answer expected %b actual %b", $time, exp_word.answer,
                   out_data.answer);
          errors++;
        end
        if (out_data.dest_mask !== exp_word.dest_mask) begin
          $display("%0t: dest_mask expected %h actual %h", $time, exp_word.dest_mask,
                   out_data.dest_mask);
          errors++;
        end
        if (out_data.status !== exp_word.status) begin
          $display("%0t: status expected %b actual %b", $time, exp_word.status,
                   out_data.status);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    table_row_t rows [$];
    gcr_out_t   ok;
    gcr_out_t   bad;
    int         counts [4];
    ok = '0;
    bad = '0;
    bad.status = 1'b1;
    foreach (adj_rows[i]) adj_rows[i] = '0;
    rows = '{
      '{OP_DEST,  6'd5,  6'd0,  -1, 1, ok},
      '{OP_GRAPH, 6'd0,  6'd0,  -1, 1, ok},
      '{OP_NODE,  6'd0,  6'd0,  -1, 1, ok},
      '{OP_REACH, 6'd0,  6'd0,  -1, 1, ok},
      '{OP_ADD,   6'd63, 6'd0,  -1, 1, ok},
      '{OP_ADD,   6'd0,  6'd63, -1, 1, ok},
      '{OP_DEST,  6'd0,  6'd0,  -1, 0, ok},
      '{OP_DEST,  6'd63, 6'd0,  -1, 0, ok},
      '{OP_GRAPH, 6'd0,  6'd0,  -1, 0, ok},
      '{OP_NODE,  6'd0,  6'd0,  -1, 0, ok},
      '{OP_REACH, 6'd0,  6'd0,  -1, 0, ok},
      '{OP_REACH, 6'd63, 6'd63, -1, 0, ok},
      '{OP_ADD,   6'd0,  6'd63, -1, 1, ok},
      '{3'd5,     6'd63, 6'd63, -1, 1, ok},
      '{3'd7,     6'd0,  6'd0,  -1, 1, ok},
      '{OP_ADD,   6'd5,  6'd1,   5, 1, bad},
      '{OP_ADD,   6'd1,  6'd5,  -1, 1, bad},
      '{OP_NODE,  6'd5,  6'd0,  -1, 1, bad},
      '{OP_REACH, 6'd0,  6'd5,  -1, 1, bad},
      '{OP_DEST,  6'd63, 6'd0,  -1, 1, bad},
      '{OP_DEST,  6'd0,  6'd0,  -1, 1, ok},
      '{OP_ADD,   6'd1,  6'd2,  -1, 1, ok},
      '{OP_ADD,   6'd2,  6'd1,  -1, 1, ok},
      '{OP_NODE,  6'd0,  6'd0,  -1, 0, ok},
      '{OP_NODE,  6'd1,  6'd0,  -1, 0, ok},
      '{OP_REACH, 6'd1,  6'd1,  -1, 0, ok},
      '{OP_GRAPH, 6'd0,  6'd0,   0, 1, ok},
      '{OP_DEST,  6'd0,  6'd0,  -1, 1, bad},
      '{OP_GRAPH, 6'd0,  6'd0, 127, 0, ok}
    };
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    foreach (rows[i]) begin
      if (rows[i].cfg >= 0) write_vertex_count(rows[i].cfg);
      send_word('{operation: rows[i].op, src_node: rows[i].src, dst_node: rows[i].dst},
                rows[i].typed, rows[i].want);
    end
    // Vertex counts programmed per phase; 1 stands for a random count from 1 to 12.
    counts = '{$urandom_range(6, 16), $urandom_range(2, 30), 1, 64};
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 76 : 23) : 0;
      stall_pct = (ph == 2 || ph == 3) ? ((ph == 2) ? 76 : 23) : 0;
      write_vertex_count(counts[ph] == 1 ? $urandom_range(1, 12) : counts[ph]);
      for (int k = 0; k < RAND_PER_PHASE; k++) begin
        if (ph == 1 && k == RAND_PER_PHASE / 2) begin
          in_valid <= 1'b0;
          wait_drained();
        end
        send_word(random_word(), 1'b0, ok);
      end
    end
    write_vertex_count(2);
    send_word('{operation: OP_GRAPH, src_node: 6'd0, dst_node: 6'd0}, 1'b0, ok);
    in_valid <= 1'b0;
    wait_drained();
    repeat (300) @(posedge clk);
    if (errors == 0 && pending_answers.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
